// File: rtl/core/lse_pkg.sv
// Shared types and constants for the LSB steganography extraction core.
package lse_pkg;

  localparam int unsigned SKIP_W      = 10;
  localparam int unsigned META_GROUPS = 16;
  localparam int unsigned EXT_GROUPS  = 8;
  localparam int unsigned LEN_LAST    = 11;

  localparam logic [SKIP_W-1:0] HEADER_SKIP_RST = SKIP_W'(54);

  localparam logic [1:0] KIND_EXT     = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef struct packed {
    logic [7:0] stego_byte;
    logic       frame_start;
  } lse_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } lse_out_t;

  typedef struct packed {
    logic     valid;
    lse_out_t word;
  } lse_res_t;

endpackage

// File: rtl/core/lse_extract.sv
// Extraction state and per-word decode: header skip, bit gathering, metadata, payload.
module lse_extract (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  lse_pkg::lse_in_t         in_word,
  input  logic [lse_pkg::SKIP_W-1:0] header_skip,
  output lse_pkg::lse_res_t        res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_META,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [lse_pkg::SKIP_W-1:0]  hcount_r, hcount_nxt;
  logic [2:0]                  bit_idx_r, bit_idx_nxt;
  logic [7:0]                  bits_r, bits_nxt;
  logic [3:0]                  grp_idx_r, grp_idx_nxt;
  logic [31:0]                 len_r, len_nxt;
  logic [31:0]                 remain_r, remain_nxt;

  always_comb begin
    phase_t      ph;
    phase_t      ph_w;
    logic [lse_pkg::SKIP_W-1:0] hc;
    logic [2:0]  bi;
    logic [7:0]  ab;
    logic [7:0]  ab_new;
    logic [3:0]  gi;
    logic [31:0] len;
    logic [31:0] rem;
    logic [31:0] rem_dec;
    logic [31:0] len_new;
    logic        go;
    logic        ended;
    ph      = in_word.frame_start ? PH_HEADER : phase_r;
    hc      = in_word.frame_start ? '0 : hcount_r;
    bi      = in_word.frame_start ? '0 : bit_idx_r;
    ab      = in_word.frame_start ? '0 : bits_r;
    gi      = in_word.frame_start ? '0 : grp_idx_r;
    len     = in_word.frame_start ? '0 : len_r;
    rem     = in_word.frame_start ? '0 : remain_r;
    ph_w    = ph;
    go      = 1'b0;
    ended   = 1'b0;
    ab_new  = ab | (8'(in_word.stego_byte[0]) << bi);
    rem_dec = rem - 32'd1;
    len_new = len | (32'(ab_new) << {gi[1:0], 3'b000});

    phase_nxt   = ph;
    hcount_nxt  = hc;
    bit_idx_nxt = bi;
    bits_nxt    = ab;
    grp_idx_nxt = gi;
    len_nxt     = len;
    remain_nxt  = rem;
    res         = '0;

    case (ph)
      PH_HEADER: begin
        if (hc < header_skip) begin
          hcount_nxt = hc + 1'b1;
        end else begin
          go        = 1'b1;
          ph_w      = PH_META;
          phase_nxt = PH_META;
        end
      end
      PH_META, PH_PAYLOAD: go = 1'b1;
      default: go = 1'b0;
    endcase

    if (go) begin
      if (bi != 3'd7) begin
        bit_idx_nxt = bi + 3'd1;
        bits_nxt    = ab_new;
      end else begin
        bit_idx_nxt = '0;
        bits_nxt    = '0;
        if (ph_w == PH_PAYLOAD) begin
          remain_nxt     = rem_dec;
          res.valid      = 1'b1;
          res.word.kind  = lse_pkg::KIND_PAYLOAD;
          res.word.value = 32'(ab_new);
          res.word.last  = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          if (gi < 4'(lse_pkg::EXT_GROUPS)) begin
            res.valid      = 1'b1;
            res.word.kind  = lse_pkg::KIND_EXT;
            res.word.value = 32'(ab_new);
          end else if (gi <= 4'(lse_pkg::LEN_LAST)) begin
            len_nxt = len_new;
            if (gi == 4'(lse_pkg::LEN_LAST)) begin
              res.valid      = 1'b1;
              res.word.value = len_new;
              if (len_new[31]) begin
                res.word.kind = lse_pkg::KIND_INVALID;
                res.word.last = 1'b1;
                phase_nxt     = PH_DONE;
                ended         = 1'b1;
              end else if (len_new == '0) begin
                res.word.kind = lse_pkg::KIND_LENGTH;
                res.word.last = 1'b1;
                phase_nxt     = PH_DONE;
                ended         = 1'b1;
              end else begin
                res.word.kind = lse_pkg::KIND_LENGTH;
                remain_nxt    = len_new;
              end
            end
          end
          if (!ended) begin
            if (({1'b0, gi} + 5'd1) >= 5'(lse_pkg::META_GROUPS)) begin
              phase_nxt   = PH_PAYLOAD;
              grp_idx_nxt = '0;
            end else begin
              grp_idx_nxt = gi + 4'd1;
            end
          end
        end
      end
    end
    res.valid = res.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hcount_r  <= '0;
      bit_idx_r <= '0;
      bits_r    <= '0;
      grp_idx_r <= '0;
      len_r     <= '0;
      remain_r  <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hcount_r  <= hcount_nxt;
      bit_idx_r <= bit_idx_nxt;
      bits_r    <= bits_nxt;
      grp_idx_r <= grp_idx_nxt;
      len_r     <= len_nxt;
      remain_r  <= remain_nxt;
    end
  end

endmodule

// File: rtl/core/lse_out_reg.sv
// Result register between the decode logic and the output channel.
module lse_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  lse_pkg::lse_res_t  res,
  input  logic               out_stall,
  output logic               out_valid,
  output lse_pkg::lse_out_t  out_word,
  output logic               busy
);

  logic              valid_r;
  lse_pkg::lse_out_t word_r;

  // full and not drained this cycle
  assign busy      = valid_r & out_stall;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      word_r <= res.word;
    end
  end

endmodule

// File: rtl/core/lsb_stego_extract_core.sv
// Top level of the LSB steganography extraction core.
//
//  port group   direction  payload              handshake
//  in_*         input      lse_in_t             in_valid / in_stall
//  out_*        output     lse_out_t            out_valid / out_stall
//  cfg_*        input      header_skip, 10 bit  cfg_wr_en
//
// One word per cycle while in_stall is low; a result appears in the cycle after its input word.
// Latency is set by the single result register after the decode logic.
// Reset is synchronous: header_skip returns to 54, all extraction state clears.
// in_stall rises only while a held result is itself stalled.
module lsb_stego_extract_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lse_pkg::lse_in_t           in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lse_pkg::lse_out_t          out_word,
  input  logic                       cfg_wr_en,
  input  logic [lse_pkg::SKIP_W-1:0] cfg_wr_data
);

  logic [lse_pkg::SKIP_W-1:0] header_skip_r;
  logic                       in_accept;
  lse_pkg::lse_res_t          res;

  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= lse_pkg::HEADER_SKIP_RST;
    end else if (cfg_wr_en) begin
      header_skip_r <= cfg_wr_data;
    end
  end

  lse_extract u_extract (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .in_word     (in_word),
    .header_skip (header_skip_r),
    .res         (res)
  );

  lse_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .busy      (in_stall)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid && out_word == $past(res.word))
    else $error("decoded result not captured");

  a_ext_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == lse_pkg::KIND_EXT |-> !out_word.last)
    else $error("extension word marked last");

  a_invalid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == lse_pkg::KIND_INVALID
      |-> out_word.value[31] && out_word.last)
    else $error("invalid length word malformed");

endmodule
